@@ sv/tsq_pkg.sv @@
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared widths, reset values, result codes and controller/datapath signal
// groups for the tick sequence quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsq_pkg;

  localparam int unsigned SEQ_BITS_DEF = 32;
  localparam int unsigned NOW_W        = 63;
  localparam int unsigned PERIOD_W     = 32;
  localparam int unsigned SEQ_OUT_W    = 32;
  localparam int unsigned TOTAL_W      = 64;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd100000000;

  typedef enum logic [1:0] {
    ST_IN_ORDER  = 2'd0,
    ST_RESYNC    = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_REJECT    = 2'd3
  } tsq_status_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch sample, move anchor
    logic prep;      // elapsed = now - anchor
    logic check;     // range/zero check, load divider
    logic div_step;  // one restoring division step
    logic mul;       // quotient * period
    logic classify;  // tick time, duplicate/resync/gap decision
    logic commit;    // load result register, bump totals
  } tsq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic reject;    // meaningful while check is issued
  } tsq_stat_t;

endpackage

`default_nettype wire

@@ sv/tsq_datapath.sv @@
// ----------------------------------------------------------------------------
// tsq_datapath
// Anchor tracking, serial divider, tick-time multiply-add, classification,
// running totals and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsq_datapath import tsq_pkg::*; #(
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [PERIOD_W-1:0]  cfg_period_ns_i,
  input  wire logic                 clock_valid_i,
  input  wire logic [NOW_W-1:0]     now_ns_i,
  input  wire tsq_cmd_t             cmd_i,
  output tsq_stat_t                 stat_o,
  output logic [1:0]                status_o,
  output logic [SEQ_OUT_W-1:0]      tick_seq_o,
  output logic [NOW_W-1:0]          tick_time_ns_o,
  output logic [SEQ_OUT_W-1:0]      gap_o,
  output logic [TOTAL_W-1:0]        skipped_total_o,
  output logic [TOTAL_W-1:0]        duplicate_total_o,
  output logic [TOTAL_W-1:0]        resync_total_o,
  output logic [TOTAL_W-1:0]        reject_total_o
);

  localparam int unsigned HI_W   = NOW_W - SEQ_BITS;
  localparam int unsigned CMP_W  = (HI_W > PERIOD_W) ? HI_W : PERIOD_W;
  localparam int unsigned PROD_W = SEQ_BITS + PERIOD_W;

  logic [PERIOD_W-1:0] period_q;
  logic [NOW_W-1:0]    now_q;
  logic [NOW_W-1:0]    anchor_q;
  logic                anchor_set_q;
  logic                rej_q;
  logic [NOW_W-1:0]    elapsed_q;
  logic [PERIOD_W-1:0] rem_q;
  logic [SEQ_BITS-1:0] dvd_q;
  logic [PROD_W-1:0]   prod_q;
  logic [NOW_W-1:0]    time_q;
  tsq_status_e         class_q;
  logic [SEQ_BITS-1:0] gap_q;
  logic                emitted_q;
  logic [SEQ_BITS-1:0] last_q;
  logic [TOTAL_W-1:0]  skipped_q;
  logic [TOTAL_W-1:0]  dup_q;
  logic [TOTAL_W-1:0]  resync_q;
  logic [TOTAL_W-1:0]  reject_q;
  tsq_status_e         out_status_q;
  logic [SEQ_BITS-1:0] out_seq_q;
  logic [NOW_W-1:0]    out_time_q;
  logic [SEQ_BITS-1:0] out_gap_q;

  logic                ovf;
  logic                period_zero;
  logic [PERIOD_W:0]   trial;
  logic                trial_ge;
  logic                move_anchor;

  assign move_anchor = clock_valid_i && (!anchor_set_q || (now_ns_i < anchor_q));
  // quotient overflows SEQ_BITS exactly when the upper dividend part reaches the period
  assign ovf         = CMP_W'(elapsed_q[NOW_W-1:SEQ_BITS]) >= CMP_W'(period_q);
  assign period_zero = (period_q == '0);
  assign trial       = {rem_q, dvd_q[SEQ_BITS-1]};
  assign trial_ge    = trial >= {1'b0, period_q};

  assign stat_o.reject = rej_q || period_zero || ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= PERIOD_RESET;
      anchor_q     <= '0;
      anchor_set_q <= 1'b0;
      rej_q        <= 1'b0;
      emitted_q    <= 1'b0;
      last_q       <= '0;
      skipped_q    <= '0;
      dup_q        <= '0;
      resync_q     <= '0;
      reject_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        period_q <= cfg_period_ns_i;
      end
      if (cmd_i.accept) begin
        rej_q <= !clock_valid_i;
        if (move_anchor) begin
          anchor_q     <= now_ns_i;
          anchor_set_q <= 1'b1;
        end
      end
      if (cmd_i.check) begin
        rej_q <= rej_q || period_zero || ovf;
      end
      if (cmd_i.classify) begin
        emitted_q <= 1'b1;
        last_q    <= dvd_q;
      end
      if (cmd_i.commit) begin
        if (rej_q) begin
          reject_q <= reject_q + TOTAL_W'(1);
        end else begin
          case (class_q)
            ST_IN_ORDER:  skipped_q <= skipped_q + TOTAL_W'(gap_q);
            ST_RESYNC:    resync_q  <= resync_q + TOTAL_W'(1);
            ST_DUPLICATE: dup_q     <= dup_q + TOTAL_W'(1);
            default:      ;
          endcase
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q <= now_ns_i;
    end
    if (cmd_i.prep) begin
      elapsed_q <= now_q - anchor_q;
    end
    if (cmd_i.check) begin
      rem_q <= PERIOD_W'(elapsed_q[NOW_W-1:SEQ_BITS]);
      dvd_q <= elapsed_q[SEQ_BITS-1:0];
    end
    if (cmd_i.div_step) begin
      // remainder stays below period, so trial - period fits PERIOD_W bits
      rem_q <= trial_ge ? PERIOD_W'(trial - {1'b0, period_q}) : trial[PERIOD_W-1:0];
      dvd_q <= {dvd_q[SEQ_BITS-2:0], trial_ge};
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(dvd_q) * PROD_W'(period_q);
    end
    if (cmd_i.classify) begin
      time_q <= anchor_q + NOW_W'(prod_q);
      gap_q  <= '0;
      if (!emitted_q) begin
        class_q <= ST_IN_ORDER;
      end else if (dvd_q == last_q) begin
        class_q <= ST_DUPLICATE;
      end else if (dvd_q < last_q) begin
        class_q <= ST_RESYNC;
      end else begin
        class_q <= ST_IN_ORDER;
        gap_q   <= dvd_q - last_q - SEQ_BITS'(1);
      end
    end
    if (cmd_i.commit) begin
      if (rej_q) begin
        out_status_q <= ST_REJECT;
        out_seq_q    <= '0;
        out_time_q   <= '0;
        out_gap_q    <= '0;
      end else begin
        out_status_q <= class_q;
        out_seq_q    <= dvd_q;
        out_time_q   <= time_q;
        out_gap_q    <= gap_q;
      end
    end
  end

  assign status_o          = out_status_q;
  assign tick_seq_o        = SEQ_OUT_W'(out_seq_q);
  assign tick_time_ns_o    = out_time_q;
  assign gap_o             = SEQ_OUT_W'(out_gap_q);
  assign skipped_total_o   = skipped_q;
  assign duplicate_total_o = dup_q;
  assign resync_total_o    = resync_q;
  assign reject_total_o    = reject_q;

  // gap is only nonzero on an in-order emission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.classify && (!emitted_q || dvd_q <= last_q) |=> gap_q == '0)
    else $error("tsq: gap set outside in-order step");

  // a rejected result never carries a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && rej_q |=> out_seq_q == '0 && out_time_q == '0)
    else $error("tsq: rejected result carries tick");

  // the reject total moves only on a rejected commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.commit && rej_q) |=> $stable(reject_q))
    else $error("tsq: reject total moved without reject");

endmodule

`default_nettype wire

@@ sv/tsq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsq_ctrl
// Sequencer for one sample at a time: handshakes, divider step count and
// result-register valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tsq_ctrl import tsq_pkg::*; #(
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire tsq_stat_t stat_i,
  output tsq_cmd_t       cmd_o
);

  localparam int unsigned CNT_BITS = $clog2(SEQ_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_CLASS = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        cnt_d       = CNT_BITS'(SEQ_BITS - 1);
        state_d     = stat_i.reject ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_BITS'(1);
        if (cnt_q == '0) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CLASS;
      end
      S_CLASS: begin
        cmd_o.classify = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        // wait until the result register can take the new result
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("tsq: more than one datapath command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_PREP)
    else $error("tsq: request accepted without starting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && cnt_q == '0 |=> state_q == S_MUL)
    else $error("tsq: divider step count wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("tsq: committed result not presented");

endmodule

`default_nettype wire

@@ sv/tick_sequence_quantizer.sv @@
// ----------------------------------------------------------------------------
// tick_sequence_quantizer
// Turns nanosecond clock samples into tick numbers relative to an anchor.
//
// Input channel (in_valid_i/in_ready_o) takes one request: clock_valid_i and
// now_ns_i. Each request gives exactly one result on the output channel
// (out_valid_o/out_ready_i): status, tick number, tick time, gap and the four
// running totals after this request.
// The result comes from the restoring divider, which retires one quotient bit
// per cycle; a rejected request skips the divider. One request is worked on
// at a time; the next is taken the cycle after the result is loaded.
// The result sits in an output register: a new request is accepted while it
// waits, and only the final load waits for the receiver to drain it.
// cfg_period_ns_i is written through cfg_valid_i (cfg_ready_o is always
// high). The user must write it only while no request is in flight; the
// block itself does not enforce this.
// Reset clears anchor, last tick and all totals; period returns to 0.1 s.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_sequence_quantizer import tsq_pkg::*; #(
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [PERIOD_W-1:0]  cfg_period_ns_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 clock_valid_i,
  input  wire logic [NOW_W-1:0]     now_ns_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [1:0]                status_o,
  output logic [SEQ_OUT_W-1:0]      tick_seq_o,
  output logic [NOW_W-1:0]          tick_time_ns_o,
  output logic [SEQ_OUT_W-1:0]      gap_o,
  output logic [TOTAL_W-1:0]        skipped_total_o,
  output logic [TOTAL_W-1:0]        duplicate_total_o,
  output logic [TOTAL_W-1:0]        resync_total_o,
  output logic [TOTAL_W-1:0]        reject_total_o
);

  tsq_cmd_t  cmd;
  tsq_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tsq_ctrl #(
    .SEQ_BITS (SEQ_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tsq_datapath #(
    .SEQ_BITS (SEQ_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_period_ns_i   (cfg_period_ns_i),
    .clock_valid_i     (clock_valid_i),
    .now_ns_i          (now_ns_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .tick_seq_o        (tick_seq_o),
    .tick_time_ns_o    (tick_time_ns_o),
    .gap_o             (gap_o),
    .skipped_total_o   (skipped_total_o),
    .duplicate_total_o (duplicate_total_o),
    .resync_total_o    (resync_total_o),
    .reject_total_o    (reject_total_o)
  );

endmodule

`default_nettype wire
